[rtl/core/rmc_pkg.sv]
// Radio meter calibration package: meter kind codes, breakpoint table type,
// per-segment reciprocal constants and the calibration breakpoint tables.
// No dependencies.
package rmc_pkg;

    localparam logic [1:0] KIND_SMETER = 2'd0;
    localparam logic [1:0] KIND_SWR    = 2'd1;
    localparam logic [1:0] KIND_ALC    = 2'd2;
    localparam logic [1:0] KIND_PWR    = 2'd3;

    localparam int NUM_KINDS = 4;
    localparam int NUM_BP    = 12;
    localparam int BP_IDX_W  = $clog2(NUM_BP);

    // quotient = (num * recip) >> RECIP_SHIFT, exact for num < 2**17
    localparam int          RECIP_SHIFT = 34;
    localparam logic [63:0] RECIP_ONE   = 64'd1 << RECIP_SHIFT;

    localparam logic [31:0] RECIP_8   = 32'((RECIP_ONE + 64'd7) / 64'd8);
    localparam logic [31:0] RECIP_9   = 32'((RECIP_ONE + 64'd8) / 64'd9);
    localparam logic [31:0] RECIP_17  = 32'((RECIP_ONE + 64'd16) / 64'd17);
    localparam logic [31:0] RECIP_24  = 32'((RECIP_ONE + 64'd23) / 64'd24);
    localparam logic [31:0] RECIP_95  = 32'((RECIP_ONE + 64'd94) / 64'd95);
    localparam logic [31:0] RECIP_48  = 32'((RECIP_ONE + 64'd47) / 64'd48);
    localparam logic [31:0] RECIP_52  = 32'((RECIP_ONE + 64'd51) / 64'd52);
    localparam logic [31:0] RECIP_54  = 32'((RECIP_ONE + 64'd53) / 64'd54);
    localparam logic [31:0] RECIP_306 = 32'((RECIP_ONE + 64'd305) / 64'd306);
    localparam logic [31:0] RECIP_128 = 32'((RECIP_ONE + 64'd127) / 64'd128);
    localparam logic [31:0] RECIP_214 = 32'((RECIP_ONE + 64'd213) / 64'd214);
    localparam logic [31:0] RECIP_296 = 32'((RECIP_ONE + 64'd295) / 64'd296);

    // recip belongs to the segment that ends at this breakpoint;
    // it is 1/span for the S-meter and 1/(2*span) for the rounded kinds
    typedef struct packed {
        logic [7:0]        raw;
        logic signed [9:0] val;
        logic [31:0]       recip;
    } t_bp;

    typedef t_bp t_bp_row [NUM_BP];

    localparam t_bp BP_TAB [NUM_KINDS][NUM_BP] = '{
        '{  // S-meter, dB re S9
            '{8'd0,   -10'sd60, 32'd0},
            '{8'd17,  -10'sd54, RECIP_17},
            '{8'd25,  -10'sd48, RECIP_8},
            '{8'd34,  -10'sd42, RECIP_9},
            '{8'd51,  -10'sd36, RECIP_17},
            '{8'd68,  -10'sd30, RECIP_17},
            '{8'd85,  -10'sd24, RECIP_17},
            '{8'd102, -10'sd18, RECIP_17},
            '{8'd119, -10'sd12, RECIP_17},
            '{8'd136, -10'sd6,  RECIP_17},
            '{8'd160, 10'sd0,   RECIP_24},
            '{8'd255, 10'sd60,  RECIP_95}
        },
        '{  // SWR, hundredths
            '{8'd12,  10'sd100, 32'd0},
            '{8'd39,  10'sd135, RECIP_54},
            '{8'd65,  10'sd150, RECIP_52},
            '{8'd89,  10'sd200, RECIP_48},
            '{8'd242, 10'sd500, RECIP_306},
            '{8'd255, 10'sd500, 32'd0},
            '{8'd255, 10'sd500, 32'd0},
            '{8'd255, 10'sd500, 32'd0},
            '{8'd255, 10'sd500, 32'd0},
            '{8'd255, 10'sd500, 32'd0},
            '{8'd255, 10'sd500, 32'd0},
            '{8'd255, 10'sd500, 32'd0}
        },
        '{  // ALC, percent
            '{8'd0,   10'sd0,   32'd0},
            '{8'd64,  10'sd100, RECIP_128},
            '{8'd255, 10'sd100, 32'd0},
            '{8'd255, 10'sd100, 32'd0},
            '{8'd255, 10'sd100, 32'd0},
            '{8'd255, 10'sd100, 32'd0},
            '{8'd255, 10'sd100, 32'd0},
            '{8'd255, 10'sd100, 32'd0},
            '{8'd255, 10'sd100, 32'd0},
            '{8'd255, 10'sd100, 32'd0},
            '{8'd255, 10'sd100, 32'd0},
            '{8'd255, 10'sd100, 32'd0}
        },
        '{  // RF power, percent
            '{8'd0,   10'sd0,   32'd0},
            '{8'd148, 10'sd50,  RECIP_296},
            '{8'd255, 10'sd100, RECIP_214},
            '{8'd255, 10'sd100, 32'd0},
            '{8'd255, 10'sd100, 32'd0},
            '{8'd255, 10'sd100, 32'd0},
            '{8'd255, 10'sd100, 32'd0},
            '{8'd255, 10'sd100, 32'd0},
            '{8'd255, 10'sd100, 32'd0},
            '{8'd255, 10'sd100, 32'd0},
            '{8'd255, 10'sd100, 32'd0},
            '{8'd255, 10'sd100, 32'd0}
        }
    };

    // index of the last real breakpoint per kind
    localparam logic [BP_IDX_W-1:0] BP_LAST [NUM_KINDS] = '{
        BP_IDX_W'(11), BP_IDX_W'(4), BP_IDX_W'(1), BP_IDX_W'(2)
    };

endpackage

[rtl/core/rmc_if.sv]
// Valid/ready channel interfaces for the radio meter calibration block:
// request channel (kind, raw byte) and result channel (calibrated value).
// Depends on rmc_pkg.
interface rmc_in_if import rmc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] raw_reading;

    modport source (output valid, output req_type, output raw_reading, input ready);
    modport sink   (input valid, input req_type, input raw_reading, output ready);
endinterface

interface rmc_out_if import rmc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic signed [9:0] meter_value;
    logic [3:0]        s_unit;
    logic [5:0]        over_s9_db;

    modport source (output valid, output meter_value, output s_unit, output over_s9_db,
                    input ready);
    modport sink   (input valid, input meter_value, input s_unit, input over_s9_db,
                    output ready);
endinterface

[rtl/core/radio_meter_calibration_top.sv]
// Radio meter calibration: four-stage pipeline that maps a raw meter byte
// to a calibrated value by piecewise-linear interpolation.
// Depends on rmc_pkg and the rmc_in_if / rmc_out_if interfaces.
//
// Usage:
//   i_in  carries one request per transaction: req_type (0 S-meter, 1 SWR,
//         2 ALC, 3 RF power) and raw_reading.
//   o_out carries one result per request, in request order: meter_value,
//         s_unit and over_s9_db (the last two are zero except for S-meter).
//   A request is registered through r_s1, r_s2, r_s3 and r_s4 before
//   o_out.valid rises. One transaction per cycle is sustained while
//   o_out.ready stays high.
//   Stages: segment search and offsets, slope multiply, reciprocal
//   multiply for the segment division, S-unit / over-S9 rounding.
//   The reciprocal multiply (17 x 32 bits) sets the stage depth.
//   Reset clears all stage valid bits; no output is valid after reset.
//   When the receiver stalls the whole pipeline holds and i_in.ready drops
//   only while the output stage holds an untaken result; nothing is lost
//   or repeated.
module radio_meter_calibration_top
    import rmc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    rmc_in_if.sink   i_in,
    rmc_out_if.source o_out
);

    logic w_en;

    // stage 1: segment select
    logic                r_s1_v;
    logic [1:0]          r_s1_kind;
    logic signed [9:0]   r_s1_base;
    logic [7:0]          r_s1_diff;
    logic [8:0]          r_s1_d;
    logic [7:0]          r_s1_span;
    logic [31:0]         r_s1_recip;

    logic signed [9:0]   n_s1_base;
    logic [7:0]          n_s1_diff;
    logic [8:0]          n_s1_d;
    logic [7:0]          n_s1_span;
    logic [31:0]         n_s1_recip;

    // stage 2: numerator
    logic                r_s2_v;
    logic [1:0]          r_s2_kind;
    logic signed [9:0]   r_s2_base;
    logic [16:0]         r_s2_num;
    logic [31:0]         r_s2_recip;
    logic [16:0]         n_s2_num;

    // stage 3: quotient and value
    logic                r_s3_v;
    logic [1:0]          r_s3_kind;
    logic signed [9:0]   r_s3_val;
    logic signed [9:0]   n_s3_val;

    // stage 4: output
    logic                r_s4_v;
    logic signed [9:0]   r_s4_val;
    logic [3:0]          r_s4_su;
    logic [5:0]          r_s4_over;
    logic [3:0]          n_s4_su;
    logic [5:0]          n_s4_over;

    assign w_en       = !r_s4_v || o_out.ready;
    assign i_in.ready = w_en;

    always_comb begin
        logic [BP_IDX_W-1:0] cnt;
        t_bp                 lo;
        t_bp                 hi;
        t_bp                 first;
        t_bp                 last;
        logic signed [9:0]   dv;
        cnt   = BP_IDX_W'(1);
        for (int k = 1; k < NUM_BP - 1; k++) begin
            cnt = cnt + BP_IDX_W'(i_in.raw_reading > BP_TAB[i_in.req_type][k].raw);
        end
        first = BP_TAB[i_in.req_type][0];
        last  = BP_TAB[i_in.req_type][BP_LAST[i_in.req_type]];
        hi    = BP_TAB[i_in.req_type][cnt];
        lo    = BP_TAB[i_in.req_type][cnt - BP_IDX_W'(1)];
        dv    = hi.val - lo.val;
        if (i_in.raw_reading <= first.raw) begin
            n_s1_base  = first.val;
            n_s1_diff  = '0;
            n_s1_d     = '0;
            n_s1_span  = '0;
            n_s1_recip = '0;
        end else if (i_in.raw_reading >= last.raw) begin
            n_s1_base  = last.val;
            n_s1_diff  = '0;
            n_s1_d     = '0;
            n_s1_span  = '0;
            n_s1_recip = '0;
        end else begin
            n_s1_base  = lo.val;
            n_s1_diff  = i_in.raw_reading - lo.raw;
            n_s1_d     = dv[8:0];
            n_s1_span  = hi.raw - lo.raw;
            n_s1_recip = hi.recip;
        end
    end

    always_comb begin
        logic [16:0] prod;
        prod = 17'(r_s1_diff) * 17'(r_s1_d);
        if (r_s1_kind == KIND_SMETER) begin
            n_s2_num = prod;
        end else begin
            n_s2_num = {prod[15:0], 1'b0} + 17'(r_s1_span);
        end
    end

    always_comb begin
        logic [48:0] prod;
        prod     = 49'(r_s2_num) * 49'(r_s2_recip);
        n_s3_val = r_s2_base + $signed({1'b0, prod[RECIP_SHIFT+8:RECIP_SHIFT]});
    end

    always_comb begin
        logic [6:0]  x;
        logic [12:0] m6;
        logic [4:0]  q6;
        logic [6:0]  y;
        logic [14:0] m10;
        logic [3:0]  q10;
        x   = 7'(10'sd3 - r_s3_val);
        m6  = 13'(x) * 13'd43;       // floor(x/6) for x < 128
        q6  = m6[12:8];
        y   = 7'(r_s3_val + 10'sd5);
        m10 = 15'(y) * 15'd205;      // floor(y/10) for y < 128
        q10 = m10[14:11];
        n_s4_su   = '0;
        n_s4_over = '0;
        if (r_s3_kind == KIND_SMETER) begin
            if (r_s3_val[9]) begin
                n_s4_su = (q6 > 5'd9) ? 4'd0 : 4'(5'd9 - q6);
            end else begin
                n_s4_su   = 4'd9;
                n_s4_over = 6'(q10) * 6'd10;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_in.valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_kind  <= i_in.req_type;
            r_s1_base  <= n_s1_base;
            r_s1_diff  <= n_s1_diff;
            r_s1_d     <= n_s1_d;
            r_s1_span  <= n_s1_span;
            r_s1_recip <= n_s1_recip;

            r_s2_kind  <= r_s1_kind;
            r_s2_base  <= r_s1_base;
            r_s2_num   <= n_s2_num;
            r_s2_recip <= r_s1_recip;

            r_s3_kind  <= r_s2_kind;
            r_s3_val   <= n_s3_val;

            r_s4_val   <= r_s3_val;
            r_s4_su    <= n_s4_su;
            r_s4_over  <= n_s4_over;
        end
    end

    assign o_out.valid       = r_s4_v;
    assign o_out.meter_value = r_s4_val;
    assign o_out.s_unit      = r_s4_su;
    assign o_out.over_s9_db  = r_s4_over;

endmodule
